// ===== hdl/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// acp_pkg: shared types and constants for the ADC calibrate and place block
// Configuration record, queue entry format, mode, command and register codes.
// ----------------------------------------------------------------------------
package acp_pkg;

   // Placement modes
   localparam logic [2:0] MODE_PEAK  = 3'd0;
   localparam logic [2:0] MODE_PLAIN = 3'd1;
   localparam logic [2:0] MODE_RAND  = 3'd2;
   localparam logic [2:0] MODE_CMP4  = 3'd3;
   localparam logic [2:0] MODE_CMP5  = 3'd4;

   // Input commands
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_MODE          = 3'd0;
   localparam logic [2:0] CSR_STRIDE        = 3'd1;
   localparam logic [2:0] CSR_START_OFFSET  = 3'd2;
   localparam logic [2:0] CSR_ODD_START     = 3'd3;
   localparam logic [2:0] CSR_RECORD_LENGTH = 3'd4;
   localparam logic [2:0] CSR_GAIN          = 3'd5;
   localparam logic [2:0] CSR_BALANCE       = 3'd6;
   localparam logic [2:0] CSR_CENTER        = 3'd7;

   localparam int CSR_DATA_W = 16;

   // Calibration arithmetic
   localparam int          PROD_W     = 28;
   localparam int          GAIN_FRAC  = 14;
   localparam logic [7:0]  VAL_MAX    = 8'd255;

   // Queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam int ADDR_W    = 10;
   localparam int MAX_WRITE = 3;

   typedef struct packed {
      logic [2:0]         mode;
      logic [6:0]         stride;
      logic signed [10:0] start_offset;
      logic               odd_start;
      logic [10:0]        record_length;
      logic [15:0]        gain;
      logic signed [8:0]  balance;
      logic [7:0]         center;
   } acp_cfg_type;

   // One classified word: up to three writes, each picks sample 0 or 1
   typedef struct packed {
      logic [15:0]                       word;
      logic [1:0]                        cnt;
      logic [MAX_WRITE-1:0][ADDR_W-1:0]  addr;
      logic [MAX_WRITE-1:0]              sel;
      logic                              done;
   } acp_op_type;

endpackage

// ===== hdl/adc_calibrate_and_place_samples_unit.sv =====
// ----------------------------------------------------------------------------
// adc_calibrate_and_place_samples_unit: calibrate ADC samples, place in record
// Top level: configuration registers, classifying front, queue, back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one transaction per acquisition word: req_cmd selects a
//          record start or a sample word, req_sample_word holds two samples
//          (low byte first). req_ready drops only while the four-entry queue
//          between front and back is full.
//   rsp_*  carries one transaction per record write: address, calibrated
//          value, last write of its word, and record-complete flag.
//   csr_*  writes configuration registers 0..7; always ready. Write only
//          while no transaction is in flight.
//   Path: queue, multiply register, scale and clamp register, rsp register.
//   Throughput: one word per cycle while each word yields at most one write
//   and rsp_ready stays high; a word with several writes holds the back end's
//   write sequencer until its last write, one write per cycle on the rsp port.
//   Reset: clears record state (no record active) and loads default config.
//   Receiver stall: the rsp register holds; the back end pipeline and then the
//   queue fill, after which req_ready drops.
// ----------------------------------------------------------------------------
module adc_calibrate_and_place_samples_unit #(
   parameter int MAX_RECORD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_sample_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_address,
   output logic [7:0]  rsp_value,
   output logic        rsp_last,
   output logic        rsp_record_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   acp_pkg::acp_cfg_type cfg_ff, cfg_in;

   logic                req_acc;
   logic                push_vld;
   acp_pkg::acp_op_type push_op;
   logic                q_full, q_vld, q_pop;
   acp_pkg::acp_op_type q_head;

   // Configuration registers are always writable
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            acp_pkg::CSR_MODE:          cfg_in.mode          = csr_data[2:0];
            acp_pkg::CSR_STRIDE:        cfg_in.stride        = csr_data[6:0];
            acp_pkg::CSR_START_OFFSET:  cfg_in.start_offset  = $signed(csr_data[10:0]);
            acp_pkg::CSR_ODD_START:     cfg_in.odd_start     = csr_data[0];
            acp_pkg::CSR_RECORD_LENGTH: cfg_in.record_length = csr_data[10:0];
            acp_pkg::CSR_GAIN:          cfg_in.gain          = csr_data[15:0];
            acp_pkg::CSR_BALANCE:       cfg_in.balance       = $signed(csr_data[8:0]);
            acp_pkg::CSR_CENTER:        cfg_in.center        = csr_data[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= acp_pkg::MODE_PLAIN;
         cfg_ff.stride        <= 7'd1;
         cfg_ff.start_offset  <= 11'sd0;
         cfg_ff.odd_start     <= 1'b0;
         cfg_ff.record_length <= 11'd1024;
         cfg_ff.gain          <= 16'd16384;
         cfg_ff.balance       <= 9'sd0;
         cfg_ff.center        <= 8'd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept a word whenever the queue has room; words with no writes
   // update the front state only and never enter the queue.
   assign req_ready = !q_full;
   assign req_acc   = req_valid && req_ready;

   // Front: record position, mode phase, dummy-word and odd-start handling
   acp_front #(
      .MAX_RECORD (MAX_RECORD)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .acc             (req_acc),
      .req_cmd         (req_cmd),
      .req_sample_word (req_sample_word),
      .push_vld        (push_vld),
      .push_op         (push_op)
   );

   // Queue: lets the front keep accepting while the back end drains writes
   acp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push_vld),
      .push_op (push_op),
      .pop     (q_pop),
      .full    (q_full),
      .vld     (q_vld),
      .head    (q_head)
   );

   // Back: multiply stage, scale and clamp stage, write sequencer, rsp register
   acp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_vld           (q_vld),
      .q_op            (q_head),
      .q_pop           (q_pop),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_address     (rsp_address),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last),
      .rsp_record_done (rsp_record_done)
   );

endmodule

// ===== hdl/acp_front.sv =====
// ----------------------------------------------------------------------------
// acp_front: record state and write classification
// Tracks position and mode state per accepted word and builds the write list.
// ----------------------------------------------------------------------------
module acp_front #(
   parameter int MAX_RECORD = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  acp_pkg::acp_cfg_type cfg,
   input  logic                 acc,
   input  logic                 req_cmd,
   input  logic [15:0]          req_sample_word,
   output logic                 push_vld,
   output acp_pkg::acp_op_type  push_op
);

   localparam int PosRaw = $clog2(MAX_RECORD + 256) + 1;
   localparam int PosW   = (PosRaw > 11) ? PosRaw : 11;
   localparam logic signed [PosW-1:0] PosOne  = PosW'(1);
   localparam logic signed [PosW-1:0] PosZero = PosW'(0);

   logic signed [PosW-1:0] pos_ff, pos_in, pos_new, start_pos;
   logic signed [PosW-1:0] len, strd, p1, p2;
   logic [2:0]             gp_ff, gp_in, gp_new, gp_cur;
   logic                   dummy_ff, dummy_in;
   logic                   odd_ff, odd_in, odd_new;
   logic                   act_ff, act_in;
   logic [2:0]             mode_eff;
   logic [31:0]            len_wide;
   logic                   in0, in1;
   logic [3:0]             c_vld;
   logic [3:0][acp_pkg::ADDR_W-1:0] c_addr;
   logic [3:0]             c_sel;
   logic [2:0]             n_wr;

   assign mode_eff = (cfg.mode > acp_pkg::MODE_CMP5) ? acp_pkg::MODE_PLAIN : cfg.mode;
   assign len_wide = ({21'd0, cfg.record_length} > 32'(MAX_RECORD)) ?
                     32'(MAX_RECORD) : {21'd0, cfg.record_length};
   assign len  = $signed({1'b0, len_wide[PosW-2:0]});
   assign strd = $signed(PosW'((cfg.stride == 7'd0) ? 7'd1 : cfg.stride));
   assign p1   = pos_ff + strd;
   assign p2   = p1 + strd;
   assign in0  = !pos_ff[PosW-1] && (pos_ff < len);
   assign in1  = !p1[PosW-1] && (p1 < len);
   assign gp_cur    = (gp_ff > 3'd4) ? 3'd0 : gp_ff;
   assign start_pos = (mode_eff == acp_pkg::MODE_PEAK) ? PosOne : PosW'(cfg.start_offset);

   // candidate writes in emission order
   always_comb begin
      c_vld   = '0;
      c_addr  = '0;
      c_sel   = '0;
      pos_new = pos_ff;
      gp_new  = gp_ff;
      odd_new = odd_ff;
      case (mode_eff)
         acp_pkg::MODE_PEAK: begin
            c_vld[0]  = in0;
            c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
            c_vld[1]  = in0 && (pos_ff == PosOne);
            if (p1 < len) begin
               c_vld[2]  = in1;
               c_addr[2] = p1[acp_pkg::ADDR_W-1:0];
               c_sel[2]  = 1'b1;
               c_vld[3]  = in1 && (p1 == PosOne);
               c_sel[3]  = 1'b1;
               pos_new   = p2;
            end else begin
               pos_new = p1;
            end
         end
         acp_pkg::MODE_RAND: begin
            c_vld[0]  = in0;
            c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
            pos_new   = p1;
         end
         acp_pkg::MODE_CMP4: begin
            if (gp_ff == 3'd0) begin
               c_vld[0]  = in0;
               c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
               pos_new   = p1;
               gp_new    = 3'd1;
            end else begin
               gp_new = 3'd0;
            end
         end
         acp_pkg::MODE_CMP5: begin
            if (gp_cur == 3'd0) begin
               c_vld[0]  = in0;
               c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
               pos_new   = p1;
            end else if (gp_cur == 3'd2 && pos_ff < len) begin
               c_vld[0]  = in0;
               c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
               c_sel[0]  = 1'b1;
               pos_new   = p1;
            end
            gp_new = (gp_cur >= 3'd4) ? 3'd0 : gp_cur + 3'd1;
         end
         default: begin
            if (odd_ff) begin
               c_vld[0]  = in0;
               c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
               c_sel[0]  = 1'b1;
               odd_new   = 1'b0;
               pos_new   = p1;
            end else begin
               c_vld[0]  = in0;
               c_addr[0] = pos_ff[acp_pkg::ADDR_W-1:0];
               c_vld[2]  = in1;
               c_addr[2] = p1[acp_pkg::ADDR_W-1:0];
               c_sel[2]  = 1'b1;
               pos_new   = p2;
            end
         end
      endcase
   end

   // pack valid candidates into consecutive slots
   always_comb begin
      n_wr         = 3'd0;
      push_op.addr = '0;
      push_op.sel  = '0;
      for (int k = 0; k < 4; k++) begin
         if (c_vld[k] && n_wr < 3'd3) begin
            push_op.addr[n_wr[1:0]] = c_addr[k];
            push_op.sel[n_wr[1:0]]  = c_sel[k];
            n_wr = n_wr + 3'd1;
         end
      end
      push_op.word = req_sample_word;
      push_op.cnt  = n_wr[1:0];
      push_op.done = !(pos_new < len);
   end

   assign push_vld     = acc && (req_cmd == acp_pkg::CMD_SAMPLE) && act_ff && !dummy_ff &&
                         (n_wr != 3'd0);

   always_comb begin
      pos_in   = pos_ff;
      gp_in    = gp_ff;
      dummy_in = dummy_ff;
      odd_in   = odd_ff;
      act_in   = act_ff;
      if (acc) begin
         if (req_cmd == acp_pkg::CMD_START) begin
            pos_in   = start_pos;
            gp_in    = 3'd0;
            dummy_in = 1'b1;
            odd_in   = (mode_eff == acp_pkg::MODE_PLAIN) && cfg.odd_start;
            act_in   = start_pos < len;
         end else if (act_ff) begin
            if (dummy_ff) begin
               dummy_in = 1'b0;
            end else begin
               pos_in = pos_new;
               gp_in  = gp_new;
               odd_in = odd_new;
               act_in = pos_new < len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= PosZero;
         gp_ff    <= 3'd0;
         dummy_ff <= 1'b1;
         odd_ff   <= 1'b0;
         act_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         gp_ff    <= gp_in;
         dummy_ff <= dummy_in;
         odd_ff   <= odd_in;
         act_ff   <= act_in;
      end
   end

endmodule

// ===== hdl/acp_fifo.sv =====
// ----------------------------------------------------------------------------
// acp_fifo: short queue of classified words
// Decouples the front from the calibration back end.
// ----------------------------------------------------------------------------
module acp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  acp_pkg::acp_op_type push_op,
   input  logic                pop,
   output logic                full,
   output logic                vld,
   output acp_pkg::acp_op_type head
);

   acp_pkg::acp_op_type             mem_ff [acp_pkg::QUEUE_DEPTH];
   logic [acp_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [acp_pkg::QUEUE_AW:0]      cnt_ff, cnt_in;

   assign full = (cnt_ff == (acp_pkg::QUEUE_AW + 1)'(acp_pkg::QUEUE_DEPTH));
   assign vld  = (cnt_ff != '0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== hdl/acp_back.sv =====
// ----------------------------------------------------------------------------
// acp_back: calibration pipeline and write sequencer
// Multiplies, scales and clamps both samples, then emits one write per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module acp_back (
   input  logic                clock,
   input  logic                reset,
   input  acp_pkg::acp_cfg_type cfg,
   input  logic                q_vld,
   input  acp_pkg::acp_op_type q_op,
   output logic                q_pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [9:0]          rsp_address,
   output logic [7:0]          rsp_value,
   output logic                rsp_last,
   output logic                rsp_record_done
);

   localparam int PW = acp_pkg::PROD_W;

   function automatic logic [7:0] calib(input logic signed [PW-1:0] p, input logic [7:0] c);
      logic signed [PW-1:0] t;
      logic signed [13:0]   v;
      t = (p + (p[PW-1] ? PW'((1 << acp_pkg::GAIN_FRAC) - 1) : PW'(0))) >>> acp_pkg::GAIN_FRAC;
      v = $signed({6'd0, c}) + t[13:0];
      if (v < 0) begin
         return 8'd0;
      end else if (v > $signed({6'd0, acp_pkg::VAL_MAX})) begin
         return acp_pkg::VAL_MAX;
      end else begin
         return v[7:0];
      end
   endfunction

   logic signed [10:0]    d0, d1;
   logic signed [16:0]    gain_s;
   logic signed [PW-1:0]  prod0, prod1;

   logic                  a_vld_ff, a_vld_in;
   acp_pkg::acp_op_type   a_op_ff;
   logic signed [PW-1:0]  a_p0_ff, a_p1_ff;

   logic                  b_vld_ff, b_vld_in;
   acp_pkg::acp_op_type   b_op_ff;
   logic [1:0][7:0]       b_val_ff;
   logic [1:0]            b_idx_ff, b_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [9:0]            rsp_address_ff;
   logic [7:0]            rsp_value_ff;
   logic                  rsp_last_ff, rsp_record_done_ff;

   logic                  out_ld, b_last, b_free, a_mv, a_free;

   assign gain_s = $signed({1'b0, cfg.gain});
   assign d0     = $signed({3'd0, q_op.word[7:0]}) - $signed({3'd0, cfg.center});
   assign d1     = $signed({3'd0, q_op.word[15:8]}) + 11'(cfg.balance) -
                   $signed({3'd0, cfg.center});
   assign prod0  = d0 * gain_s;
   assign prod1  = d1 * gain_s;

   assign out_ld = b_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign b_last = (b_idx_ff == (b_op_ff.cnt - 2'd1));
   assign b_free = !b_vld_ff || (out_ld && b_last);
   assign a_mv   = a_vld_ff && b_free;
   assign a_free = !a_vld_ff || a_mv;
   assign q_pop  = q_vld && a_free;

   assign a_vld_in     = q_pop ? 1'b1 : (a_mv ? 1'b0 : a_vld_ff);
   assign b_vld_in     = a_mv ? 1'b1 : (b_free ? 1'b0 : b_vld_ff);
   assign b_idx_in     = a_mv ? 2'd0 : (out_ld ? b_idx_ff + 2'd1 : b_idx_ff);
   assign rsp_valid_in = out_ld ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         b_idx_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         b_idx_ff     <= b_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_op_ff <= q_op;
         a_p0_ff <= prod0;
         a_p1_ff <= prod1;
      end
      if (a_mv) begin
         b_op_ff     <= a_op_ff;
         b_val_ff[0] <= calib(a_p0_ff, cfg.center);
         b_val_ff[1] <= calib(a_p1_ff, cfg.center);
      end
      if (out_ld) begin
         rsp_address_ff     <= b_op_ff.addr[b_idx_ff];
         rsp_value_ff       <= b_val_ff[b_op_ff.sel[b_idx_ff]];
         rsp_last_ff        <= b_last;
         rsp_record_done_ff <= b_op_ff.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_address     = rsp_address_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_record_done = rsp_record_done_ff;

endmodule

// ===== hdl/acp_checker.sv =====
// ----------------------------------------------------------------------------
// acp_checker: port-level checks for the calibrate and place unit
// Attached to the top level through a bind statement.
// ----------------------------------------------------------------------------
module acp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [9:0] rsp_address,
   input logic [7:0] rsp_value,
   input logic       rsp_last,
   input logic       rsp_record_done
);

   // Drop any pending write at reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Hold a stalled write
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address) &&
      $stable(rsp_value) && $stable(rsp_last) && $stable(rsp_record_done))
      else $error("stalled rsp transaction changed");

   // Writes of one word follow each other without gaps
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside the writes of one word");

   // All writes of one word agree on record completion
   a_done_agrees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_record_done == $past(rsp_record_done))
      else $error("record_done differs within one word");

endmodule

bind adc_calibrate_and_place_samples_unit acp_checker u_acp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_address     (rsp_address),
   .rsp_value       (rsp_value),
   .rsp_last        (rsp_last),
   .rsp_record_done (rsp_record_done)
);
